FILE: src/brt_pkg.sv
package brt_pkg;

    // Default number of records the table can hold.
    localparam int TABLE_DEPTH = 16;

    // Fixed widths of the result fields that carry positions and counts.
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;
    localparam logic [1:0] REQ_FIRST  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_BADSLOT = 2'd3;

    // Record kinds; for a find the last code selects an address match.
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_MAPPED = 2'd1;
    localparam logic [1:0] KIND_SHARED = 2'd2;
    localparam logic [1:0] KIND_ADDR   = 2'd3;

    // Request transaction payload.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  kind;
        logic [63:0] address;
        logic [31:0] size;
        logic [31:0] key;
        logic [63:0] name_tag;
        logic [3:0]  slot;
    } t_req;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  hit_slot;
        logic [4:0]  count;
        logic        empty_res;
        logic [1:0]  match_kind;
        logic [63:0] match_address;
        logic [31:0] match_size;
        logic [31:0] match_key;
        logic [63:0] match_name;
    } t_res;

    // One stored record as it sits in the table memory.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] address;
        logic [31:0] size;
        logic [31:0] key;
        logic [63:0] name_tag;
    } t_rec;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         rd_en;
        logic         wr_en;
        logic         wr_from_req;
        logic         load_req;
        logic         res_en;
        logic         res_found;
        logic         res_empty;
        logic [1:0]   res_status;
        logic [3:0]   res_slot;
        logic [4:0]   res_count;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
    } t_sts;

endpackage

FILE: src/brt_ram.sv
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one read port with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/brt_dp.sv
module brt_dp #(
    parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brt_pkg::t_cmd        i_cmd,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_addr,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_addr,
    input  brt_pkg::t_req        i_req,
    output brt_pkg::t_sts        o_sts,
    output logic                 o_done,
    output brt_pkg::t_res        o_res
);

    localparam int RW = $bits(brt_pkg::t_rec);

    brt_pkg::t_req r_req;
    brt_pkg::t_rec rd_rec;
    brt_pkg::t_rec wr_rec;
    brt_pkg::t_rec req_rec;
    brt_pkg::t_res r_res;
    brt_pkg::t_res n_res;
    logic          r_done;
    logic [RW-1:0] rd_data;
    logic          match;

    // The request is held while a scan compares stored records against it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
    end

    // A new record comes from the request; a shifted one from the last read.
    always_comb begin
        req_rec.kind     = i_req.kind;
        req_rec.address  = i_req.address;
        req_rec.size     = i_req.size;
        req_rec.key      = i_req.key;
        req_rec.name_tag = i_req.name_tag;
        wr_rec = i_cmd.wr_from_req ? req_rec : rd_rec;
    end

    brt_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (wr_rec),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_rec = brt_pkg::t_rec'(rd_data);

    // Compare the record just read with the held request.
    always_comb begin
        match = 1'b0;
        if (r_req.req_type == brt_pkg::REQ_FIRST) begin
            match = 1'b1;
        end else begin
            unique case (r_req.kind)
                brt_pkg::KIND_ALLOC: begin
                    match = (rd_rec.kind == brt_pkg::KIND_ALLOC) && (rd_rec.size == r_req.size);
                end
                brt_pkg::KIND_MAPPED: begin
                    match = (rd_rec.kind == brt_pkg::KIND_MAPPED)
                            && (rd_rec.name_tag == r_req.name_tag);
                end
                brt_pkg::KIND_SHARED: begin
                    match = (rd_rec.kind == brt_pkg::KIND_SHARED) && (rd_rec.key == r_req.key);
                end
                brt_pkg::KIND_ADDR: begin
                    match = (rd_rec.address == r_req.address);
                end
            endcase
        end
    end

    assign o_sts.match = match;

    // Assemble the result; record fields are zero unless a record was found.
    always_comb begin
        n_res               = '0;
        n_res.status        = i_cmd.res_status;
        n_res.hit_slot      = i_cmd.res_slot;
        n_res.count         = i_cmd.res_count;
        n_res.empty_res     = i_cmd.res_empty;
        if (i_cmd.res_found) begin
            n_res.match_kind    = rd_rec.kind;
            n_res.match_address = rd_rec.address;
            n_res.match_size    = rd_rec.size;
            n_res.match_key     = rd_rec.key;
            n_res.match_name    = rd_rec.name_tag;
        end
    end

    // Result register and its one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_en) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: src/brt_ctrl.sv
module brt_ctrl #(
    parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  brt_pkg::t_req        i_req,
    input  brt_pkg::t_sts        i_sts,
    output logic                 o_busy,
    output brt_pkg::t_cmd        o_cmd,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_rd_addr,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_wr_addr
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW  = brt_pkg::SLOT_W;
    localparam int OCW = brt_pkg::COUNT_W;
    localparam int XW  = (CW > SW) ? CW + 1 : SW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic          r_pv;
    logic          n_pv;
    logic [AW-1:0] r_pidx;
    logic [AW-1:0] n_pidx;
    logic          issue;
    logic [XW-1:0] slot_ext;
    logic [XW-1:0] count_ext;
    brt_pkg::t_cmd cmd;

    assign issue     = (r_idx < r_count);
    assign slot_ext  = XW'(i_req.slot);
    assign count_ext = XW'(r_count);

    // Next-state logic. Reads go out one per cycle; r_pv marks that the
    // memory output holds entry r_pidx in the current cycle.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pidx    = r_pidx;
        cmd       = '0;
        o_rd_addr = r_idx[AW-1:0];
        o_wr_addr = r_pidx - AW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.req_type)
                        brt_pkg::REQ_INSERT: begin
                            cmd.res_en = 1'b1;
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                cmd.res_status = brt_pkg::ST_FULL;
                            end else begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_from_req = 1'b1;
                                o_wr_addr       = r_count[AW-1:0];
                                n_count         = r_count + CW'(1);
                                cmd.res_status  = brt_pkg::ST_OK;
                                cmd.res_slot    = SW'(r_count);
                            end
                        end
                        brt_pkg::REQ_REMOVE: begin
                            if (slot_ext >= count_ext) begin
                                cmd.res_en     = 1'b1;
                                cmd.res_status = brt_pkg::ST_BADSLOT;
                            end else begin
                                n_idx   = CW'(slot_ext + XW'(1));
                                n_state = S_SHIFT;
                            end
                        end
                        brt_pkg::REQ_FIND, brt_pkg::REQ_FIRST: begin
                            if (r_count == '0) begin
                                cmd.res_en     = 1'b1;
                                cmd.res_status = brt_pkg::ST_NONE;
                            end else begin
                                cmd.load_req = 1'b1;
                                n_idx        = '0;
                                n_state      = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.rd_en = issue;
                if (issue) begin
                    n_idx  = r_idx + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                end
                if (r_pv && i_sts.match) begin
                    cmd.res_en     = 1'b1;
                    cmd.res_found  = 1'b1;
                    cmd.res_status = brt_pkg::ST_OK;
                    cmd.res_slot   = SW'(r_pidx);
                    n_pv           = 1'b0;
                    n_state        = S_IDLE;
                end else if (!issue) begin
                    cmd.res_en     = 1'b1;
                    cmd.res_status = brt_pkg::ST_NONE;
                    n_state        = S_IDLE;
                end
            end
            S_SHIFT: begin
                // Read entry k while entry k-2 is overwritten with entry k-1, read the cycle before.
                cmd.rd_en = issue;
                cmd.wr_en = r_pv;
                if (issue) begin
                    n_idx  = r_idx + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                end else begin
                    n_count        = r_count - CW'(1);
                    cmd.res_en     = 1'b1;
                    cmd.res_status = brt_pkg::ST_OK;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        cmd.res_count = OCW'(n_count);
        cmd.res_empty = (n_count == '0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_pidx  <= n_pidx;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    // The record count never passes the table depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("record count above table depth");

    // A find or first scan never modifies the table.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !cmd.wr_en)
        else $error("table written during a scan");

    // Every result returns the controller to idle.
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_en |=> (r_state == S_IDLE))
        else $error("controller busy after a result");

    // A shift only writes slots that hold records.
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && cmd.wr_en) |-> (CW'(o_wr_addr) < r_count))
        else $error("shift writes beyond the record count");

endmodule

FILE: src/block_record_table.sv
// Insert, a bad-slot remove, and find or first on an empty table give their result in the cycle
// after the start transaction and never raise busy. Find and first scan the records from slot 0
// until the first hit or the last record; remove moves each record above the slot down by one.
// Throughput: one transaction at a time, set by the single read port of the record memory,
// which reads one entry per cycle during a scan or a shift. The receiver cannot stall results.
// Reset (synchronous, active low) clears the record count; record memory needs no clearing pass.
module block_record_table #(
    parameter int TABLE_DEPTH = brt_pkg::TABLE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  brt_pkg::t_req i_req,
    output logic          o_done,
    output brt_pkg::t_res o_res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    brt_pkg::t_cmd cmd;
    brt_pkg::t_sts sts;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    // Sequencer for requests, scans and shifts.
    brt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_sts     (sts),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    // Record memory, compare logic and result register.
    brt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_req     (i_req),
        .o_sts     (sts),
        .o_done    (o_done),
        .o_res     (o_res)
    );

endmodule
